>>> hw/rtl/kci_pkg.sv
// ----------------------------------------------------------------------------
// kci_pkg
// shared types, codes and constants of the keyframe corner interpolator
// ----------------------------------------------------------------------------
package kci_pkg;

  // geometry of one keyframe row
  localparam int CORNERS       = 4;
  localparam int COORDS        = 2 * CORNERS;
  localparam int COORD_W       = 16;
  localparam int ROW_W         = COORDS * COORD_W;

  // default store depth in keyframes
  localparam int MAX_KEYFRAMES = 64;

  // field widths
  localparam int MODE_W        = 2;
  localparam int KEY_W         = 6;
  localparam int TIME_W        = 32;
  localparam int SEG_OUT_W     = 6;
  localparam int STEP_W        = 16;
  localparam int COUNT_W       = 7;

  // configuration port
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEYFRAME_COUNT = 2'd1;

  localparam logic [STEP_W-1:0]  STEP_RESET  = 16'd300;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd2;

  // request modes
  localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SAMPLE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

  // radix-2 divider steps per division
  localparam int DIV_STEPS     = 32;
  localparam int ITER_W        = 5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PERIOD,
    ST_MOD,
    ST_SEG,
    ST_RD_A,
    ST_RD_B,
    ST_MUL,
    ST_SUM,
    ST_LERP,
    ST_DONE
  } state_t;

endpackage

>>> hw/rtl/kci_in_if.sv
// ----------------------------------------------------------------------------
// kci_in_if
// request channel: load, sample or restart
// ----------------------------------------------------------------------------
interface kci_in_if;
  logic                                  valid;
  logic                                  ready;
  logic        [kci_pkg::MODE_W-1:0]     mode;
  logic        [kci_pkg::KEY_W-1:0]      key_index;
  logic signed [kci_pkg::COORD_W-1:0]    load_c0_x;
  logic signed [kci_pkg::COORD_W-1:0]    load_c0_y;
  logic signed [kci_pkg::COORD_W-1:0]    load_c1_x;
  logic signed [kci_pkg::COORD_W-1:0]    load_c1_y;
  logic signed [kci_pkg::COORD_W-1:0]    load_c2_x;
  logic signed [kci_pkg::COORD_W-1:0]    load_c2_y;
  logic signed [kci_pkg::COORD_W-1:0]    load_c3_x;
  logic signed [kci_pkg::COORD_W-1:0]    load_c3_y;
  logic        [kci_pkg::TIME_W-1:0]     now_time;

  modport source (
    output valid, mode, key_index, load_c0_x, load_c0_y, load_c1_x, load_c1_y,
           load_c2_x, load_c2_y, load_c3_x, load_c3_y, now_time,
    input  ready
  );
  modport sink (
    input  valid, mode, key_index, load_c0_x, load_c0_y, load_c1_x, load_c1_y,
           load_c2_x, load_c2_y, load_c3_x, load_c3_y, now_time,
    output ready
  );
endinterface

>>> hw/rtl/kci_out_if.sv
// ----------------------------------------------------------------------------
// kci_out_if
// result channel: interpolated corners and segment
// ----------------------------------------------------------------------------
interface kci_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [kci_pkg::COORD_W-1:0]    corner0_x;
  logic signed [kci_pkg::COORD_W-1:0]    corner0_y;
  logic signed [kci_pkg::COORD_W-1:0]    corner1_x;
  logic signed [kci_pkg::COORD_W-1:0]    corner1_y;
  logic signed [kci_pkg::COORD_W-1:0]    corner2_x;
  logic signed [kci_pkg::COORD_W-1:0]    corner2_y;
  logic signed [kci_pkg::COORD_W-1:0]    corner3_x;
  logic signed [kci_pkg::COORD_W-1:0]    corner3_y;
  logic        [kci_pkg::SEG_OUT_W-1:0]  segment_index;

  modport source (
    output valid, corner0_x, corner0_y, corner1_x, corner1_y,
           corner2_x, corner2_y, corner3_x, corner3_y, segment_index,
    input  ready
  );
  modport sink (
    input  valid, corner0_x, corner0_y, corner1_x, corner1_y,
           corner2_x, corner2_y, corner3_x, corner3_y, segment_index,
    output ready
  );
endinterface

>>> hw/rtl/kci_cfg_if.sv
// ----------------------------------------------------------------------------
// kci_cfg_if
// configuration register write channel
// ----------------------------------------------------------------------------
interface kci_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [kci_pkg::CFG_IDX_W-1:0]     index;
  logic [kci_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/keyframe_corner_interpolator_top.sv
// ----------------------------------------------------------------------------
// keyframe_corner_interpolator_top
// looping linear interpolation of four corner points over keyframes
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                                   request
//  in_chan   in   mode, key_index, load_c*_x/y, now_time    load / sample / restart
//  out_chan  out  corner*_x/y, segment_index                one per sample
//  cfg_chan  in   index, data                               register write
//
//  load/restart: taken while idle, a load writes one 128-bit keyframe row; a sample
//  steps through period, mod, seg, row reads A and B, mul, sum, lerp and done, with
//  three 32-step radix-2 divisions (elapsed mod period, phase / step, eight
//  parallel lerp lane dividers); the next request is taken back in idle
//  reset is synchronous, active low; the corner store has no reset
//  a finished sample waits in its last state while the output register is
//  full; new requests are taken while a result waits on out_chan
//
module keyframe_corner_interpolator_top #(
  parameter int MAX_KEYFRAMES = kci_pkg::MAX_KEYFRAMES
) (
  input  logic       clk,
  input  logic       rst_n,
  kci_in_if.sink     in_chan,
  kci_out_if.source  out_chan,
  kci_cfg_if.sink    cfg_chan
);

  // derived widths
  localparam int AW = (MAX_KEYFRAMES > 1) ? $clog2(MAX_KEYFRAMES) : 1;  // row address
  localparam int CW = $clog2(MAX_KEYFRAMES + 1);                        // clamped count
  localparam int PW = CW + kci_pkg::STEP_W;                             // loop period
  localparam int NL = kci_pkg::COORDS;
  localparam int CRW = kci_pkg::COORD_W;
  localparam int SW = kci_pkg::STEP_W;
  localparam logic [31:0] MAX32 = 32'(MAX_KEYFRAMES);
  localparam logic [kci_pkg::ITER_W-1:0] ITER_LAST =
    kci_pkg::ITER_W'(kci_pkg::DIV_STEPS - 1);

  // control
  kci_pkg::state_t state_r, state_nxt;
  logic [kci_pkg::ITER_W-1:0] iter_r;
  logic                       started_r;
  logic [31:0]                start_time_r;
  logic [SW-1:0]              cfg_step_r;
  logic [kci_pkg::COUNT_W-1:0] cfg_count_r;
  logic                       out_valid_r;

  // per-sample working registers
  logic [SW-1:0]  step_r;
  logic [CW-1:0]  count_r;
  logic [AW-1:0]  seg_r;
  logic [SW-1:0]  off_r;

  // shared scalar divider: elapsed mod period, then phase / step
  logic [31:0]    sd_dvd_r;
  logic [PW-1:0]  sd_rem_r;
  logic [PW-1:0]  sd_dsr_r;
  logic [PW:0]    sd_sh;
  logic           sd_ge;
  logic [PW-1:0]  sd_rem_new;
  logic [31:0]    sd_dvd_new;

  // corner store, one keyframe per row
  logic [kci_pkg::ROW_W-1:0] corner_store [MAX_KEYFRAMES];
  logic [kci_pkg::ROW_W-1:0] mem_q_r;
  logic [kci_pkg::ROW_W-1:0] row_a_r;
  logic [kci_pkg::ROW_W-1:0] wr_row;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;

  // lerp lanes
  logic signed [CRW-1:0] coord_a   [NL];
  logic signed [CRW-1:0] coord_b   [NL];
  logic signed [32:0]    mul_a     [NL];
  logic signed [32:0]    mul_b     [NL];
  logic signed [32:0]    prod_a_r  [NL];
  logic signed [32:0]    prod_b_r  [NL];
  logic        [33:0]    lsum      [NL];
  logic        [33:0]    lmag      [NL];
  logic        [31:0]    ld_dvd_r  [NL];
  logic        [SW-1:0]  ld_rem_r  [NL];
  logic                  ld_neg_r  [NL];
  logic        [SW:0]    ld_sh     [NL];
  logic                  ld_ge     [NL];
  logic        [SW-1:0]  ld_rem_new[NL];
  logic        [31:0]    ld_dvd_new[NL];
  logic        [CRW-1:0] lane_res  [NL];
  logic        [CRW-1:0] out_coord_r[NL];
  logic        [kci_pkg::SEG_OUT_W-1:0] out_seg_r;

  // request decode
  logic        in_ready;
  logic        in_fire;
  logic        is_load;
  logic        is_sample;
  logic        is_restart;
  logic [31:0] kidx32;
  logic [31:0] cnt32;
  logic [31:0] cnt_eff;
  logic [SW-1:0] step_eff;
  logic        done_go;
  logic        div_active;
  logic [SW-1:0] step_m_off;

  assign in_fire    = in_chan.valid && in_ready;
  assign is_load    = (in_chan.mode == kci_pkg::MODE_LOAD);
  assign is_sample  = (in_chan.mode == kci_pkg::MODE_SAMPLE);
  assign is_restart = (in_chan.mode == kci_pkg::MODE_RESTART);
  assign kidx32     = 32'(in_chan.key_index);
  assign wr_en      = in_fire && is_load && (kidx32 < MAX32);
  assign wr_addr    = kidx32[AW-1:0];
  assign wr_row     = {in_chan.load_c0_x, in_chan.load_c0_y, in_chan.load_c1_x,
                       in_chan.load_c1_y, in_chan.load_c2_x, in_chan.load_c2_y,
                       in_chan.load_c3_x, in_chan.load_c3_y};

  // clamped step and keyframe count, taken when a sample is accepted
  assign step_eff = (cfg_step_r == '0) ? SW'(1) : cfg_step_r;
  assign cnt32    = 32'(cfg_count_r);
  always_comb begin
    if (cnt32 < 32'd2) begin
      cnt_eff = 32'd2;
    end else if (cnt32 > MAX32) begin
      cnt_eff = MAX32;
    end else begin
      cnt_eff = cnt32;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kci_pkg::ST_IDLE:   if (in_fire && is_sample) state_nxt = kci_pkg::ST_PERIOD;
      kci_pkg::ST_PERIOD: state_nxt = kci_pkg::ST_MOD;
      kci_pkg::ST_MOD:    if (iter_r == ITER_LAST) state_nxt = kci_pkg::ST_SEG;
      kci_pkg::ST_SEG:    if (iter_r == ITER_LAST) state_nxt = kci_pkg::ST_RD_A;
      kci_pkg::ST_RD_A:   state_nxt = kci_pkg::ST_RD_B;
      kci_pkg::ST_RD_B:   state_nxt = kci_pkg::ST_MUL;
      kci_pkg::ST_MUL:    state_nxt = kci_pkg::ST_SUM;
      kci_pkg::ST_SUM:    state_nxt = kci_pkg::ST_LERP;
      kci_pkg::ST_LERP:   if (iter_r == ITER_LAST) state_nxt = kci_pkg::ST_DONE;
      kci_pkg::ST_DONE:   if (done_go) state_nxt = kci_pkg::ST_IDLE;
      default:            state_nxt = kci_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready   = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = seg_r;
    div_active = 1'b0;
    done_go    = 1'b0;
    case (state_r)
      kci_pkg::ST_IDLE: in_ready = 1'b1;
      kci_pkg::ST_MOD,
      kci_pkg::ST_SEG,
      kci_pkg::ST_LERP: div_active = 1'b1;
      kci_pkg::ST_RD_A: rd_en = 1'b1;
      kci_pkg::ST_RD_B: begin
        rd_en   = 1'b1;
        rd_addr = seg_r + AW'(1);
      end
      kci_pkg::ST_DONE: done_go = !out_valid_r || out_chan.ready;
      default: ;
    endcase
  end

  // one restoring step of the scalar divider
  always_comb begin
    sd_sh      = {sd_rem_r, sd_dvd_r[31]};
    sd_ge      = (sd_sh >= {1'b0, sd_dsr_r});
    sd_rem_new = sd_ge ? PW'(sd_sh - {1'b0, sd_dsr_r}) : sd_sh[PW-1:0];
    sd_dvd_new = {sd_dvd_r[30:0], sd_ge};
  end

  // lane arithmetic: products, signed sum, one divider step, signed quotient
  assign step_m_off = step_r - off_r;
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      coord_a[l]    = row_a_r[(NL-1-l)*CRW +: CRW];
      coord_b[l]    = mem_q_r[(NL-1-l)*CRW +: CRW];
      mul_a[l]      = coord_a[l] * $signed({1'b0, step_m_off});
      mul_b[l]      = coord_b[l] * $signed({1'b0, off_r});
      lsum[l]       = {prod_a_r[l][32], prod_a_r[l]} + {prod_b_r[l][32], prod_b_r[l]};
      lmag[l]       = lsum[l][33] ? (34'd0 - lsum[l]) : lsum[l];
      ld_sh[l]      = {ld_rem_r[l], ld_dvd_r[l][31]};
      ld_ge[l]      = (ld_sh[l] >= {1'b0, step_r});
      ld_rem_new[l] = ld_ge[l] ? SW'(ld_sh[l] - {1'b0, step_r}) : ld_sh[l][SW-1:0];
      ld_dvd_new[l] = {ld_dvd_r[l][30:0], ld_ge[l]};
      lane_res[l]   = ld_neg_r[l] ? (CRW'(0) - ld_dvd_r[l][CRW-1:0])
                                  : ld_dvd_r[l][CRW-1:0];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= kci_pkg::ST_IDLE;
      iter_r       <= '0;
      started_r    <= 1'b0;
      start_time_r <= '0;
      cfg_step_r   <= kci_pkg::STEP_RESET;
      cfg_count_r  <= kci_pkg::COUNT_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (div_active) begin
        iter_r <= iter_r + kci_pkg::ITER_W'(1);
      end
      if (cfg_chan.valid) begin
        case (cfg_chan.index)
          kci_pkg::CFG_STEP_TIME:      cfg_step_r  <= cfg_chan.data;
          kci_pkg::CFG_KEYFRAME_COUNT: cfg_count_r <= cfg_chan.data[kci_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end
      if (in_fire && is_restart) begin
        started_r <= 1'b0;
      end else if (in_fire && is_sample && !started_r) begin
        started_r    <= 1'b1;
        start_time_r <= in_chan.now_time;
      end
      if (done_go) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      kci_pkg::ST_IDLE: begin
        step_r   <= step_eff;
        count_r  <= cnt_eff[CW-1:0];
        // first sample after restart runs from phase 0
        sd_dvd_r <= started_r ? (in_chan.now_time - start_time_r) : 32'd0;
      end
      kci_pkg::ST_PERIOD: begin
        sd_dsr_r <= PW'((count_r - CW'(1)) * step_r);
        sd_rem_r <= '0;
      end
      kci_pkg::ST_MOD: begin
        if (iter_r == ITER_LAST) begin
          // phase is the remainder; divide it by the step next
          sd_dvd_r <= 32'(sd_rem_new);
          sd_dsr_r <= PW'(step_r);
          sd_rem_r <= '0;
        end else begin
          sd_dvd_r <= sd_dvd_new;
          sd_rem_r <= sd_rem_new;
        end
      end
      kci_pkg::ST_SEG: begin
        sd_dvd_r <= sd_dvd_new;
        sd_rem_r <= sd_rem_new;
        if (iter_r == ITER_LAST) begin
          seg_r <= sd_dvd_new[AW-1:0];
          off_r <= sd_rem_new[SW-1:0];
        end
      end
      kci_pkg::ST_RD_B: row_a_r <= mem_q_r;
      kci_pkg::ST_MUL: begin
        for (int l = 0; l < NL; l++) begin
          prod_a_r[l] <= mul_a[l];
          prod_b_r[l] <= mul_b[l];
        end
      end
      kci_pkg::ST_SUM: begin
        for (int l = 0; l < NL; l++) begin
          ld_dvd_r[l] <= lmag[l][31:0];
          ld_neg_r[l] <= lsum[l][33];
          ld_rem_r[l] <= '0;
        end
      end
      kci_pkg::ST_LERP: begin
        for (int l = 0; l < NL; l++) begin
          ld_dvd_r[l] <= ld_dvd_new[l];
          ld_rem_r[l] <= ld_rem_new[l];
        end
      end
      kci_pkg::ST_DONE: begin
        if (done_go) begin
          for (int l = 0; l < NL; l++) begin
            out_coord_r[l] <= lane_res[l];
          end
          out_seg_r <= kci_pkg::SEG_OUT_W'(32'(seg_r));
        end
      end
      default: ;
    endcase
  end

  // corner store: one write port for loads, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      corner_store[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      mem_q_r <= corner_store[rd_addr];
    end
  end

  // ports
  assign in_chan.ready          = in_ready;
  assign cfg_chan.ready         = 1'b1;
  assign out_chan.valid         = out_valid_r;
  assign out_chan.corner0_x     = out_coord_r[0];
  assign out_chan.corner0_y     = out_coord_r[1];
  assign out_chan.corner1_x     = out_coord_r[2];
  assign out_chan.corner1_y     = out_coord_r[3];
  assign out_chan.corner2_x     = out_coord_r[4];
  assign out_chan.corner2_y     = out_coord_r[5];
  assign out_chan.corner3_x     = out_coord_r[6];
  assign out_chan.corner3_y     = out_coord_r[7];
  assign out_chan.segment_index = out_seg_r;

`ifndef ASSERT_OFF
  // a result only appears when a sample finishes
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == kci_pkg::ST_DONE)
    else $error("result raised outside the finishing state");

  // the segment always has a following keyframe in use
  a_seg_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == kci_pkg::ST_MUL |-> (32'(seg_r) + 32'd1) < 32'(count_r))
    else $error("segment beyond last keyframe pair");

  // the in-segment offset stays below the step
  a_off_below_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == kci_pkg::ST_MUL |-> off_r < step_r)
    else $error("segment offset not below step");

  // an accepted sample leaves the animation started
  a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && is_sample |=> started_r)
    else $error("sample did not mark the animation started");
`endif

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the keyframe corner interpolator: a directed table,
// then random phases over several step and count settings, each result checked
// field by field against a hand-written result or an in-bench interpolation predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  // ---------------------------------------------------------------------------
  // bench constants
  // ---------------------------------------------------------------------------
  localparam int RESET_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 3000;   // covers a whole sample plus stalls
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 120;
  localparam int PHASES         = 10;
  localparam int FIXED_PHASES   = 8;
  localparam int PHASE_BUDGET   = 78;     // counted requests per random phase, unused modes apart

  // codes the package leaves unnamed
  localparam logic [kci_pkg::MODE_W-1:0]    MODE_UNUSED = 2'd3;
  localparam logic [kci_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [kci_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  // ---------------------------------------------------------------------------
  // request and result types
  // coordinate lanes: 0 c0_x, 1 c0_y, 2 c1_x, 3 c1_y, ... 7 c3_y
  // ---------------------------------------------------------------------------
  typedef logic [kci_pkg::COORDS-1:0][kci_pkg::COORD_W-1:0] corner_row_t;

  typedef struct packed {
    logic [kci_pkg::MODE_W-1:0] mode;
    logic [kci_pkg::KEY_W-1:0]  key;
    corner_row_t                coord;
    logic [kci_pkg::TIME_W-1:0] now;
  } request_t;

  typedef struct packed {
    corner_row_t                   coord;
    logic [kci_pkg::SEG_OUT_W-1:0] seg;
  } corner_result_t;

  typedef struct packed {
    request_t       req;
    logic           typed;   // want holds a hand-written result
    corner_result_t want;
  } directed_row_t;

  // keyframe rows, written lane 7 first
  localparam corner_row_t SLOT0_ROW = {16'hAAAA, 16'h5555, 16'h8001, 16'h0001,
                                       16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF};
  localparam corner_row_t SLOT1_ROW = {16'h5555, 16'hAAAA, 16'h0001, 16'h8001,
                                       16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000};
  localparam corner_row_t ALL_MIN   = {kci_pkg::COORDS{16'h8000}};
  localparam corner_row_t ALL_MAX   = {kci_pkg::COORDS{16'h7FFF}};

  // ---------------------------------------------------------------------------
  // directed table, run under the reset settings (step 300, two keyframes)
  // typed rows: first sample after reset or restart, and whole loops, both
  // land on phase 0 and return keyframe 0 as it was loaded
  // ---------------------------------------------------------------------------
  localparam int DIRECTED_ROWS = 21;
  localparam directed_row_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
    '{'{kci_pkg::MODE_LOAD, 6'd0, SLOT0_ROW, 32'h0000_0000}, 1'b0, '0},
    '{'{kci_pkg::MODE_LOAD, 6'd1, SLOT1_ROW, 32'h0000_0000}, 1'b0, '0},
    '{'{kci_pkg::MODE_LOAD, 6'd63, ~SLOT0_ROW, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{MODE_UNUSED, 6'd63, ALL_MAX, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{kci_pkg::MODE_SAMPLE, 6'd0, '0, 32'hFFFF_FF00}, 1'b1, '{SLOT0_ROW, 6'd0}},
    '{'{kci_pkg::MODE_SAMPLE, 6'd0, '0, 32'h0000_002C}, 1'b1, '{SLOT0_ROW, 6'd0}},
    '{'{kci_pkg::MODE_SAMPLE, 6'd0, '0, 32'hFFFF_FF96}, 1'b0, '0},
    '{'{kci_pkg::MODE_SAMPLE, 6'd0, '0, 32'h0000_002B}, 1'b0, '0},
    '{'{kci_pkg::MODE_RESTART, 6'd0, '0, 32'h0000_0000}, 1'b0, '0},
    '{'{kci_pkg::MODE_SAMPLE, 6'd0, '0, 32'h0000_0000}, 1'b1, '{SLOT0_ROW, 6'd0}},
    '{'{kci_pkg::MODE_SAMPLE, 6'd0, '0, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{kci_pkg::MODE_RESTART, 6'd63, ALL_MIN, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{kci_pkg::MODE_RESTART, 6'd0, '0, 32'h0000_0000}, 1'b0, '0},
    '{'{kci_pkg::MODE_SAMPLE, 6'd0, '0, 32'h8000_0000}, 1'b1, '{SLOT0_ROW, 6'd0}},
    '{'{kci_pkg::MODE_LOAD, 6'd0, ALL_MIN, 32'h0000_0000}, 1'b0, '0},
    '{'{kci_pkg::MODE_LOAD, 6'd1, ALL_MAX, 32'h0000_0000}, 1'b0, '0},
    '{'{kci_pkg::MODE_SAMPLE, 6'd0, '0, 32'h8000_0258}, 1'b1, '{ALL_MIN, 6'd0}},
    '{'{kci_pkg::MODE_SAMPLE, 6'd0, '0, 32'h8000_0001}, 1'b0, '0},
    '{'{kci_pkg::MODE_SAMPLE, 6'd0, '0, 32'h8000_012B}, 1'b0, '0},
    '{'{kci_pkg::MODE_SAMPLE, 6'd0, '0, 32'h8000_0096}, 1'b0, '0},
    '{'{MODE_UNUSED, 6'd0, '0, 32'h0000_0000}, 1'b0, '0}
  };

  // settings walked by the random phases; step 0 and counts 0, 1 and 127
  // exercise the clamping, the last phases pick their own values
  localparam int PHASE_STEP  [FIXED_PHASES] = '{1, 65535, 0, 7, 13, 1000, 65535, 3};
  localparam int PHASE_COUNT [FIXED_PHASES] = '{2, 64, 5, 0, 1, 127, 2, 64};

  // ---------------------------------------------------------------------------
  // clock, reset, channels and the block
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  kci_in_if  in_chan  ();
  kci_out_if out_chan ();
  kci_cfg_if cfg_chan ();

  keyframe_corner_interpolator_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // ---------------------------------------------------------------------------
  // predictor state: own copy of registers, keyframes and animation clock
  // ---------------------------------------------------------------------------
  logic [kci_pkg::STEP_W-1:0]  cfg_step;
  logic [kci_pkg::COUNT_W-1:0] cfg_count;
  corner_row_t                 key_store   [kci_pkg::MAX_KEYFRAMES];
  bit                          key_written [kci_pkg::MAX_KEYFRAMES];
  logic [kci_pkg::TIME_W-1:0]  anim_start;
  bit                          anim_started;

  corner_result_t pending_corners [$];   // expected results, oldest first

  int mismatches      = 0;
  int results_checked = 0;
  int samples_sent    = 0;
  int loads_sent      = 0;
  int restarts_sent   = 0;
  int ignored_sent    = 0;
  int burst_left      = 0;
  int ready_hold      = 0;
  int idle_cycles     = 0;

  string lane_name [kci_pkg::COORDS] = '{"corner0_x", "corner0_y", "corner1_x",
                                         "corner1_y", "corner2_x", "corner2_y",
                                         "corner3_x", "corner3_y"};

  corner_result_t seen_result;
  corner_result_t due_result;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic longint step_in_use();
    return (cfg_step == '0) ? 1 : longint'(cfg_step);
  endfunction

  function automatic longint count_in_use();
    longint c;
    c = cfg_count;
    if (c < 2) c = 2;
    if (c > kci_pkg::MAX_KEYFRAMES) c = kci_pkg::MAX_KEYFRAMES;
    return c;
  endfunction

  // elapsed time mod loop period, then segment lookup and exact integer lerp
  function automatic corner_result_t interpolate_corners(
    input logic [kci_pkg::TIME_W-1:0] now);
    corner_result_t                     res;
    logic [kci_pkg::TIME_W-1:0]         since;
    longint                             step, count, period, phase, seg, off, num;
    logic signed [kci_pkg::COORD_W-1:0] a, b;
    step  = step_in_use();
    count = count_in_use();
    if (!anim_started) begin
      // first sample after reset or restart marks the start
      anim_started = 1'b1;
      anim_start   = now;
      phase        = 0;
    end else begin
      period = (count - 1) * step;
      since  = now - anim_start;
      phase  = longint'(since) % period;
    end
    seg = phase / step;
    if (seg > count - 2) seg = count - 2;
    off = phase - seg * step;
    for (int lane = 0; lane < kci_pkg::COORDS; lane++) begin
      a   = key_store[seg][lane];
      b   = key_store[seg + 1][lane];
      num = longint'(a) * (step - off) + longint'(b) * off;
      res.coord[lane] = kci_pkg::COORD_W'(num / step);   // truncates toward zero
    end
    res.seg = seg[kci_pkg::SEG_OUT_W-1:0];
    return res;
  endfunction

  function automatic corner_row_t random_row();
    corner_row_t row;
    for (int lane = 0; lane < kci_pkg::COORDS; lane++) begin
      case ($urandom_range(0, 7))
        0:       row[lane] = 16'h8000;
        1:       row[lane] = 16'h7FFF;
        2:       row[lane] = 16'h0000;
        3:       row[lane] = 16'hFFFF;
        default: row[lane] = kci_pkg::COORD_W'($urandom);
      endcase
    end
    return row;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // request driver: bursts of random length, random gaps between them
  // valid stays high across back-to-back requests, so it is only lowered
  // when a gap actually starts
  // ---------------------------------------------------------------------------
  task automatic send_request(input request_t req, input bit typed,
                              input corner_result_t want);
    int             gap;
    corner_result_t predicted;
    if (burst_left == 0) begin
      case ($urandom_range(0, 7))
        0, 1:    gap = 0;
        2:       gap = $urandom_range(20, 130);   // long gap, at its longest spanning a whole sample
        default: gap = $urandom_range(1, 12);
      endcase
      if (gap != 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_chan.valid     <= 1'b1;
    in_chan.mode      <= req.mode;
    in_chan.key_index <= req.key;
    in_chan.load_c0_x <= req.coord[0];
    in_chan.load_c0_y <= req.coord[1];
    in_chan.load_c1_x <= req.coord[2];
    in_chan.load_c1_y <= req.coord[3];
    in_chan.load_c2_x <= req.coord[4];
    in_chan.load_c2_y <= req.coord[5];
    in_chan.load_c3_x <= req.coord[6];
    in_chan.load_c3_y <= req.coord[7];
    in_chan.now_time  <= req.now;
    do @(posedge clk); while (!in_chan.ready);
    // accepted at this edge: update the predictor
    case (req.mode)
      kci_pkg::MODE_LOAD: begin
        key_store[req.key]   = req.coord;
        key_written[req.key] = 1'b1;
        loads_sent++;
      end
      kci_pkg::MODE_SAMPLE: begin
        predicted = interpolate_corners(req.now);
        pending_corners.insert(pending_corners.size(), typed ? want : predicted);
        samples_sent++;
      end
      kci_pkg::MODE_RESTART: begin
        anim_started = 1'b0;
        restarts_sent++;
      end
      default: ignored_sent++;
    endcase
  endtask

  // sender holds off until every pending result is back, then lingers
  task automatic settle_block(input int linger);
    in_chan.valid <= 1'b0;
    burst_left = 0;
    while (pending_corners.size() != 0) @(posedge clk);
    repeat (linger) @(posedge clk);
  endtask

  // leaves cfg valid high so consecutive writes run back to back
  task automatic write_register(input logic [kci_pkg::CFG_IDX_W-1:0] idx,
                                input logic [kci_pkg::CFG_DATA_W-1:0] value);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= value;
    do @(posedge clk); while (!cfg_chan.ready);
    case (idx)
      kci_pkg::CFG_STEP_TIME:      cfg_step  = value[kci_pkg::STEP_W-1:0];
      kci_pkg::CFG_KEYFRAME_COUNT: cfg_count = value[kci_pkg::COUNT_W-1:0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // result side: stall pattern and checker
  // the receiver alternates free-flowing stretches, hard stalls and coin flips
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      ready_hold     <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          out_chan.ready <= 1'b1;
          ready_hold     <= $urandom_range(0, 300);
        end
        1: begin
          out_chan.ready <= 1'b0;
          ready_hold     <= $urandom_range(1, 20);
        end
        default: out_chan.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      seen_result.coord = {out_chan.corner3_y, out_chan.corner3_x,
                           out_chan.corner2_y, out_chan.corner2_x,
                           out_chan.corner1_y, out_chan.corner1_x,
                           out_chan.corner0_y, out_chan.corner0_x};
      seen_result.seg   = out_chan.segment_index;
      if (pending_corners.size() == 0) begin
        report_mismatch("result arrived with no sample pending");
      end else begin
        due_result = pending_corners.pop_front();
        results_checked++;
        for (int lane = 0; lane < kci_pkg::COORDS; lane++) begin
          if (seen_result.coord[lane] !== due_result.coord[lane])
            report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                      results_checked, lane_name[lane],
                                      $signed(seen_result.coord[lane]),
                                      $signed(due_result.coord[lane])));
        end
        if (seen_result.seg !== due_result.seg)
          report_mismatch($sformatf("result %0d segment_index got %0d want %0d",
                                    results_checked, seen_result.seg, due_result.seg));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: cycles in a row with no handshake on any channel
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)
        || (cfg_chan.valid && cfg_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, idle_cycles);
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    request_t                   req;
    logic [kci_pkg::TIME_W-1:0] last_now;
    int                         step_val, count_val, items, pick;
    longint                     eff_step, eff_count;

    // known values on every request and register input from time zero
    rst_n          <= 1'b0;
    in_chan.valid  <= 1'b0;
    in_chan.mode   <= kci_pkg::MODE_LOAD;
    in_chan.key_index <= '0;
    in_chan.load_c0_x <= '0;
    in_chan.load_c0_y <= '0;
    in_chan.load_c1_x <= '0;
    in_chan.load_c1_y <= '0;
    in_chan.load_c2_x <= '0;
    in_chan.load_c2_y <= '0;
    in_chan.load_c3_x <= '0;
    in_chan.load_c3_y <= '0;
    in_chan.now_time  <= '0;
    cfg_chan.valid <= 1'b0;
    cfg_chan.index <= kci_pkg::CFG_STEP_TIME;
    cfg_chan.data  <= '0;

    // predictor reset state
    cfg_step     = kci_pkg::STEP_RESET;
    cfg_count    = kci_pkg::COUNT_RESET;
    anim_start   = '0;
    anim_started = 1'b0;
    foreach (key_written[k]) key_written[k] = 1'b0;
    last_now     = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed table under the reset settings
    foreach (DIRECTED_TABLE[r])
      send_request(DIRECTED_TABLE[r].req, DIRECTED_TABLE[r].typed, DIRECTED_TABLE[r].want);

    // random phases, each under new settings written while the block is idle
    for (int p = 0; p < PHASES; p++) begin
      settle_block(SETTLE_CYCLES);
      step_val  = (p < FIXED_PHASES) ? PHASE_STEP[p]  : $urandom_range(1, 2000);
      count_val = (p < FIXED_PHASES) ? PHASE_COUNT[p]
                                     : $urandom_range(2, kci_pkg::MAX_KEYFRAMES);
      write_register(kci_pkg::CFG_STEP_TIME, kci_pkg::CFG_DATA_W'(step_val));
      // bits above the count field must be ignored
      write_register(kci_pkg::CFG_KEYFRAME_COUNT,
                     {kci_pkg::CFG_DATA_W'($urandom_range(0, 511)) << kci_pkg::COUNT_W}
                     | kci_pkg::CFG_DATA_W'(count_val));
      if (p == 2) begin
        // spare indexes change nothing
        write_register(CFG_SPARE_2, kci_pkg::CFG_DATA_W'($urandom));
        write_register(CFG_SPARE_3, kci_pkg::CFG_DATA_W'($urandom));
      end
      cfg_chan.valid <= 1'b0;

      eff_step  = step_in_use();
      eff_count = count_in_use();
      items     = 0;

      // every keyframe in reach gets loaded before any sample reads it
      for (int k = 0; k < eff_count; k++) begin
        if (!key_written[k]) begin
          req = '{kci_pkg::MODE_LOAD, kci_pkg::KEY_W'(k), random_row(),
                  kci_pkg::TIME_W'($urandom)};
          send_request(req, 1'b0, '0);
          items++;
        end
      end

      while (items < PHASE_BUDGET) begin
        pick = $urandom_range(0, 99);
        req  = '{kci_pkg::MODE_SAMPLE, kci_pkg::KEY_W'($urandom),
                 {$urandom, $urandom, $urandom, $urandom}, kci_pkg::TIME_W'($urandom)};
        if (pick < 65) begin
          // mostly a steady clock, with loop boundaries and wild jumps mixed in
          case ($urandom_range(0, 9))
            0:       req.now = $urandom;
            1:       req.now = anim_start + kci_pkg::TIME_W'(
                                 $urandom_range(0, eff_count) * eff_step);
            2:       req.now = anim_start + kci_pkg::TIME_W'(
                                 (eff_count - 1) * eff_step - 1);
            default: req.now = last_now + kci_pkg::TIME_W'(
                                 $urandom_range(0, 2 * eff_step));
          endcase
          last_now = req.now;
          items++;
        end else if (pick < 82) begin
          req.mode  = kci_pkg::MODE_LOAD;
          req.coord = random_row();
          items++;
        end else if (pick < 90) begin
          req.mode = kci_pkg::MODE_RESTART;
          items++;
        end else begin
          req.mode = MODE_UNUSED;
        end
        send_request(req, 1'b0, '0);
      end
    end

    // drain: everything back, then linger to catch strays
    settle_block(DRAIN_CYCLES);

    $display("run: %0d samples (%0d results checked), %0d loads, %0d restarts,",
             samples_sent, results_checked, loads_sent, restarts_sent);
    $display("run: %0d unused-mode requests, %0d register settings after reset",
             ignored_sent, PHASES);
    if (mismatches == 0 && pending_corners.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("run: %0d mismatches, %0d results missing", mismatches,
               pending_corners.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/kci_pkg.sv
hw/rtl/kci_in_if.sv
hw/rtl/kci_out_if.sv
hw/rtl/kci_cfg_if.sv
hw/rtl/keyframe_corner_interpolator_top.sv
tb/testbench.sv
